[rtl/core/stereo_sample_fifo_packer_defines.svh]
// Assertion macros for the stereo sample FIFO packer.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef STEREO_SAMPLE_FIFO_PACKER_DEFINES_SVH
`define STEREO_SAMPLE_FIFO_PACKER_DEFINES_SVH

`ifndef SYNTH
`define SSFP_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssfp check failed");
`define SSFP_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssfp check failed");
`else
`define SSFP_CHECK(lbl, ante, cons)
`define SSFP_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/ssfp_pkg.sv]
// Shared types, constants and helpers for the stereo sample FIFO packer.
// No dependencies.
package ssfp_pkg;

    // DEPTH must be even: entries alternate between two banks by pointer parity
    localparam int DEPTH  = 2048;
    localparam int ROWS   = DEPTH / 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HALF_W = 16;
    localparam int FILL_W = 12;

    localparam logic [1:0] MODE_MONO   = 2'd1;
    localparam logic [1:0] MODE_STEREO = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_SERVE = 2'd1,
        OP_STOP  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] left_sample;
        logic signed [31:0] right_sample;
        logic               block_end;
    } req_beat_t;

    typedef struct packed {
        logic [31:0]       tx_word;
        logic              accepted;
        logic              underrun;
        logic              playing;
        logic [FILL_W-1:0] fill_level;
    } rsp_beat_t;

    typedef struct packed {
        logic              we;
        logic [ROW_W-1:0]  waddr;
        logic [HALF_W-1:0] wdata;
        logic              re;
        logic [ROW_W-1:0]  raddr;
    } bank_cmd_t;

    typedef struct packed {
        logic              accepted;
        logic              underrun;
        logic              playing;
        logic [FILL_W-1:0] fill_level;
        logic              left_ok;
        logic              left_odd;
        logic              right_ok;
    } stage_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    function automatic logic [ROW_W-1:0] ptr_row(input logic [PTR_W-1:0] p);
        return ROW_W'(p >> 1);
    endfunction

endpackage

[rtl/core/ssfp_bank.sv]
// One bank of sample storage: one write port, one registered read port.
// Depends on ssfp_pkg.
module ssfp_bank (
    input  logic                      clk,
    input  ssfp_pkg::bank_cmd_t       cmd,
    output logic [ssfp_pkg::HALF_W-1:0] rdata
);
    import ssfp_pkg::*;

    logic [HALF_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rdata <= mem[cmd.raddr];
        end
    end

endmodule

[rtl/core/ssfp_ctrl.sv]
// Ring control: pointers, fill count, playback flag and bank commands.
// Depends on ssfp_pkg.
module ssfp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ssfp_pkg::req_beat_t req,
    input  logic [1:0]          channel_count,
    output ssfp_pkg::bank_cmd_t cmd_even,
    output ssfp_pkg::bank_cmd_t cmd_odd,
    output ssfp_pkg::stage_t    stage
);
    import ssfp_pkg::*;

    logic [PTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              play_reg, play_next;
    logic [PTR_W-1:0]  wp1, wp2, rp1, rp2;
    logic [HALF_W-1:0] l16, r16;
    logic              room, mode_ok, push_ok, serve_ok;
    logic              left_ok, right_ok;
    logic [1:0]        pop_n;

    always_comb
    begin
        wp1      = ring_next(wp_reg);
        wp2      = ring_next(wp1);
        rp1      = ring_next(rp_reg);
        rp2      = ring_next(rp1);
        room     = count_reg <= CNT_W'(DEPTH - 2);
        mode_ok  = (channel_count == MODE_MONO) || (channel_count == MODE_STEREO);
        push_ok  = (op_t'(req.op) == OP_PUSH) && room && mode_ok;
        serve_ok = (op_t'(req.op) == OP_SERVE) && play_reg;
        left_ok  = serve_ok && (count_reg != '0);
        right_ok = serve_ok && (count_reg >= CNT_W'(2));
        pop_n    = {1'b0, left_ok} + {1'b0, right_ok};
        l16      = req.left_sample[31:16];
        r16      = (channel_count == MODE_MONO) ? l16 : req.right_sample[31:16];

        wp_next    = push_ok ? wp2 : wp_reg;
        rp_next    = right_ok ? rp2 : (left_ok ? rp1 : rp_reg);
        count_next = push_ok ? CNT_W'(count_reg + CNT_W'(2))
                             : CNT_W'(count_reg - CNT_W'(pop_n));
        play_next  = play_reg;
        if (push_ok && req.block_end)
        begin
            play_next = 1'b1;
        end
        else if (op_t'(req.op) == OP_STOP)
        begin
            play_next = 1'b0;
        end
    end

    always_comb
    begin
        cmd_even.we    = accept && push_ok;
        cmd_even.waddr = wp_reg[0] ? ptr_row(wp1) : ptr_row(wp_reg);
        cmd_even.wdata = wp_reg[0] ? r16 : l16;
        cmd_even.re    = accept && serve_ok;
        cmd_even.raddr = rp_reg[0] ? ptr_row(rp1) : ptr_row(rp_reg);

        cmd_odd.we     = accept && push_ok;
        cmd_odd.waddr  = wp_reg[0] ? ptr_row(wp_reg) : ptr_row(wp1);
        cmd_odd.wdata  = wp_reg[0] ? l16 : r16;
        cmd_odd.re     = accept && serve_ok;
        cmd_odd.raddr  = rp_reg[0] ? ptr_row(rp_reg) : ptr_row(rp1);

        stage.accepted   = push_ok || serve_ok;
        stage.underrun   = serve_ok && (count_reg < CNT_W'(2));
        stage.playing    = play_next;
        stage.fill_level = FILL_W'(count_next);
        stage.left_ok    = left_ok;
        stage.left_odd   = rp_reg[0];
        stage.right_ok   = right_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
            play_reg  <= 1'b0;
        end
        else if (accept)
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
            play_reg  <= play_next;
        end
    end

endmodule

[rtl/core/ssfp_out.sv]
// Result path: read stage that meets the bank data, then the output register.
// Depends on ssfp_pkg.
module ssfp_out (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  ssfp_pkg::stage_t            stage,
    input  logic [ssfp_pkg::HALF_W-1:0] rdata_even,
    input  logic [ssfp_pkg::HALF_W-1:0] rdata_odd,
    input  logic                        rsp_stall,
    output logic                        ready,
    output logic                        rsp_valid,
    output ssfp_pkg::rsp_beat_t         rsp
);
    import ssfp_pkg::*;

    stage_t            s1_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              out_valid_reg, out_valid_next;
    rsp_beat_t         out_reg, out_next;
    logic              s1_move;
    logic [HALF_W-1:0] left_h, right_h;

    always_comb
    begin
        s1_move        = s1_valid_reg && (!out_valid_reg || !rsp_stall);
        ready          = !s1_valid_reg || s1_move;
        s1_valid_next  = load || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && rsp_stall);

        left_h  = s1_reg.left_ok ? (s1_reg.left_odd ? rdata_odd : rdata_even) : '0;
        right_h = s1_reg.right_ok ? (s1_reg.left_odd ? rdata_even : rdata_odd) : '0;

        out_next.tx_word    = {left_h, right_h};
        out_next.accepted   = s1_reg.accepted;
        out_next.underrun   = s1_reg.underrun;
        out_next.playing    = s1_reg.playing;
        out_next.fill_level = s1_reg.fill_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg <= stage;
        end
        if (s1_move)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

[rtl/core/stereo_sample_fifo_packer.sv]
// Stereo sample FIFO packer top level: config register, ring control, banks, result path.
// Depends on ssfp_pkg, ssfp_bank, ssfp_ctrl, ssfp_out and the defines header.
//
// Usage:
//   req channel (req_valid, req_stall, req): one beat is a push of a sample
//   pair, a serve request, a stop or no operation. rsp channel (rsp_valid, rsp_stall, rsp):
//   exactly one result beat per request beat, in order.
//   cfg_we/cfg_wdata write channel_count (1 mono, 2 stereo); write only idle.
//   Storage: two banks of DEPTH/2 16-bit entries selected by pointer parity,
//   so a push writes and a serve reads both entries in the same cycle.
//   Result path: a taken request beat passes the read stage, then the output register.
//   Throughput: one request beat per cycle while req_stall is low, set by the
//   single write and single read port of each bank.
//   Reset: pointers, fill count and playback clear; channel_count becomes 2;
//   sample storage keeps its contents and needs no clearing pass.
//   Receiver stall: the output register holds its beat; one more beat waits
//   in the read stage, then req_stall rises until rsp drains.
`include "stereo_sample_fifo_packer_defines.svh"

module stereo_sample_fifo_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  logic                req_valid,
    output logic                req_stall,
    input  ssfp_pkg::req_beat_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ssfp_pkg::rsp_beat_t rsp
);
    import ssfp_pkg::*;

    logic              mono_push;
    logic [1:0]        chan_cnt_reg;
    logic              ready, accept;
    bank_cmd_t         cmd_even, cmd_odd;
    stage_t            stage;
    logic [HALF_W-1:0] rdata_even, rdata_odd;

    assign mono_push = accept && (chan_cnt_reg == MODE_MONO) && (op_t'(req.op) == OP_PUSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg <= MODE_STEREO;
        end
        else if (cfg_we)
        begin
            chan_cnt_reg <= cfg_wdata;
        end
    end

    assign accept    = req_valid && ready;
    assign req_stall = !ready;

    ssfp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req           (req),
        .channel_count (chan_cnt_reg),
        .cmd_even      (cmd_even),
        .cmd_odd       (cmd_odd),
        .stage         (stage)
    );

    ssfp_bank u_bank_even (
        .clk   (clk),
        .cmd   (cmd_even),
        .rdata (rdata_even)
    );

    ssfp_bank u_bank_odd (
        .clk   (clk),
        .cmd   (cmd_odd),
        .rdata (rdata_odd)
    );

    ssfp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .stage      (stage),
        .rdata_even (rdata_even),
        .rdata_odd  (rdata_odd),
        .rsp_stall  (rsp_stall),
        .ready      (ready),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp)
    );

    `SSFP_CHECK(a_no_stall_when_out_empty, !rsp_valid, !req_stall)
    `SSFP_CHECK(a_fill_bound, rsp_valid, rsp.fill_level <= FILL_W'(DEPTH))
    `SSFP_CHECK(a_underrun_is_serve, rsp_valid && rsp.underrun, rsp.accepted)
    `SSFP_CHECK(a_mono_push_dup, mono_push, cmd_even.wdata == cmd_odd.wdata)
    `SSFP_CHECK(a_idle_tx_zero, rsp_valid && !rsp.accepted, rsp.tx_word == 32'd0)

endmodule
